// ----- src/krev_pkg.sv -----
`default_nettype none

package krev_pkg;

  // Default depth of the group buffer and the widths of the data and configuration fields.
  localparam int MAX_GROUP_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int CFG_W         = 5;

  // Reset value of the group size register.
  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(1);

  // Controller states: gathering values, or reading a group out of the buffer.
  typedef enum logic {
    ST_ACCEPT,
    ST_DRAIN
  } state_e;

  // One buffer read issued by the controller.
  typedef struct packed {
    logic valid;
    logic last;
  } rd_req_t;

endpackage

`default_nettype wire

// ----- src/krev_ram.sv -----
`default_nettype none

module krev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/krev_ctrl.sv -----
`default_nettype none

module krev_ctrl #(
  parameter int MAX_GROUP = krev_pkg::MAX_GROUP_DEF,
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Group size register writes
  input  wire logic                        cfg_valid_i,
  input  wire logic [krev_pkg::CFG_W-1:0]  cfg_data_i,
  // Input handshake
  input  wire logic                        s_valid_i,
  input  wire logic                        s_last_i,
  output logic                             s_ready_o,
  // Buffer write and read control
  output logic                             wr_en_o,
  output logic [AW-1:0]                    wr_addr_o,
  output krev_pkg::rd_req_t                rd_req_o,
  output logic [AW-1:0]                    rd_addr_o,
  input  wire logic                        rd_grant_i
);

  localparam int FW = $clog2(MAX_GROUP + 1);
  localparam int CW = (FW > krev_pkg::CFG_W) ? FW : krev_pkg::CFG_W;

  krev_pkg::state_e             state_q, state_d;
  logic [krev_pkg::CFG_W-1:0]   cfg_q;
  logic [FW-1:0]                fill_q, fill_d;
  logic [FW-1:0]                rem_q, rem_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic                         rev_q, rev_d;
  logic                         lastf_q, lastf_d;
  logic [CW-1:0]                k_raw;
  logic [CW-1:0]                k_eff;
  logic [FW-1:0]                n_cnt;
  logic                         in_fire;

  // Group size register; the port never stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= krev_pkg::GROUP_SIZE_RST;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Effective group size: zero acts as one, larger values saturate at the buffer depth.
  assign k_raw = CW'(cfg_q);
  always_comb begin
    if (k_raw == '0) begin
      k_eff = CW'(1);
    end else if (k_raw > CW'(MAX_GROUP)) begin
      k_eff = CW'(MAX_GROUP);
    end else begin
      k_eff = k_raw;
    end
  end

  assign in_fire = s_valid_i && (state_q == krev_pkg::ST_ACCEPT);
  assign n_cnt   = fill_q + FW'(1);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krev_pkg::ST_ACCEPT;
      fill_q  <= '0;
      rem_q   <= '0;
      addr_q  <= '0;
      rev_q   <= 1'b0;
      lastf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      addr_q  <= addr_d;
      rev_q   <= rev_d;
      lastf_q <= lastf_d;
    end
  end

  // Next state: gather values, then sweep the buffer one read per granted cycle.
  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    rem_d          = rem_q;
    addr_d         = addr_q;
    rev_d          = rev_q;
    lastf_d        = lastf_q;
    s_ready_o      = 1'b0;
    wr_en_o        = 1'b0;
    wr_addr_o      = fill_q[AW-1:0];
    rd_req_o.valid = 1'b0;
    rd_req_o.last  = 1'b0;
    rd_addr_o      = addr_q;

    case (state_q)
      krev_pkg::ST_ACCEPT: begin
        s_ready_o = 1'b1;
        wr_en_o   = in_fire;
        if (in_fire) begin
          if (CW'(n_cnt) >= k_eff) begin
            // Full group: read back from the newest value down.
            state_d = krev_pkg::ST_DRAIN;
            rem_d   = n_cnt;
            addr_d  = fill_q[AW-1:0];
            rev_d   = 1'b1;
            lastf_d = s_last_i;
            fill_d  = '0;
          end else if (s_last_i) begin
            // Short tail at the end of the list: read back in arrival order.
            state_d = krev_pkg::ST_DRAIN;
            rem_d   = n_cnt;
            addr_d  = '0;
            rev_d   = 1'b0;
            lastf_d = 1'b1;
            fill_d  = '0;
          end else begin
            fill_d = n_cnt;
          end
        end
      end
      krev_pkg::ST_DRAIN: begin
        if (rd_grant_i) begin
          rd_req_o.valid = 1'b1;
          rd_req_o.last  = lastf_q && (rem_q == FW'(1));
          addr_d         = rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
          rem_d          = rem_q - FW'(1);
          if (rem_q == FW'(1)) begin
            state_d = krev_pkg::ST_ACCEPT;
          end
        end
      end
      default: begin
        state_d = krev_pkg::ST_ACCEPT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/krev_outbuf.sv -----
`default_nettype none

module krev_outbuf (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Read request issued this cycle; its data arrives from the RAM next cycle
  input  wire krev_pkg::rd_req_t                   rd_req_i,
  input  wire logic [krev_pkg::DATA_W-1:0]         rdata_i,
  output logic                                     rd_grant_o,
  // Output stream
  output logic                                     m_valid_o,
  input  wire logic                                m_ready_i,
  output logic signed [krev_pkg::DATA_W-1:0]       m_data_o,
  output logic                                     m_last_o
);

  krev_pkg::rd_req_t             req_q;
  logic [krev_pkg::DATA_W-1:0]   data_q [2];
  logic                          last_q [2];
  logic                          wptr_q;
  logic                          rptr_q;
  logic [1:0]                    cnt_q;
  logic                          push;
  logic                          pop;
  logic [2:0]                    level;

  assign push = req_q.valid;
  assign pop  = m_valid_o && m_ready_i;

  // A read may be issued when the entries held plus the read in flight,
  // less the transfer leaving now, stay below the two buffer slots.
  assign level      = 3'(cnt_q) + 3'(req_q.valid) - 3'(pop);
  assign rd_grant_o = (level < 3'd2);

  // Track the read whose data lands next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
    end else begin
      req_q <= rd_req_i;
    end
  end

  // Two-entry output queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wptr_q] <= rdata_i;
      last_q[wptr_q] <= req_q.last;
    end
  end

  assign m_valid_o = (cnt_q != '0);
  assign m_data_o  = data_q[rptr_q];
  assign m_last_o  = last_q[rptr_q];

endmodule

`default_nettype wire

// ----- src/k_group_stream_reverser_core.sv -----
// Reorders a stream of 32-bit signed values in groups of group_size (1 to MAX_GROUP; zero
// acts as one, larger values saturate). Values are gathered into a buffer RAM at one per
// cycle while the block accepts input; when a group is complete it is read back newest
// first, and when tlast arrives before the group fills, the pending values are read back
// in arrival order. The last output of a list carries tlast. While a group is read out,
// the input is held for one read per value on the single RAM read port, plus every cycle
// in which the two-entry output queue has no room because the receiver stalls. The first
// output of a group passes the state register, the RAM read register and the output
// queue after the transfer that completes the group. The output queue lets the next group
// gather while its last results wait. The group size register must be written by the
// user only while the block is idle; the block itself does not enforce this.
`default_nettype none

module k_group_stream_reverser_core #(
  parameter int MAX_GROUP = krev_pkg::MAX_GROUP_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration: group_size
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [krev_pkg::CFG_W-1:0]          cfg_data_i,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic signed [krev_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  wire logic                                s_axis_tlast,  // last
  // Output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic signed [krev_pkg::DATA_W-1:0]       m_axis_tdata,  // [31:0] value_res
  output logic                                     m_axis_tlast   // last_res
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  krev_pkg::rd_req_t             rd_req;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_grant;
  logic [krev_pkg::DATA_W-1:0]   rdata;

  assign cfg_ready_o = 1'b1;

  // Gathering and read sequencing.
  krev_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_last_i    (s_axis_tlast),
    .s_ready_o   (s_axis_tready),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .rd_req_o    (rd_req),
    .rd_addr_o   (rd_addr),
    .rd_grant_i  (rd_grant)
  );

  // Group buffer.
  krev_ram #(
    .WIDTH (krev_pkg::DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_req.valid),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Output queue.
  krev_outbuf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_req_i   (rd_req),
    .rdata_i    (rdata),
    .rd_grant_o (rd_grant),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- src/krev_checker.sv -----
`default_nettype none

module krev_checker #(
  parameter int MAX_GROUP = krev_pkg::MAX_GROUP_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  input  wire logic                                s_axis_tready,
  input  wire logic                                s_axis_tlast,
  input  wire logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic signed [krev_pkg::DATA_W-1:0]  m_axis_tdata,
  input  wire logic                                m_axis_tlast
);

  logic [7:0] pend_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Values accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_xfer) - 8'(out_xfer);
    end
  end

  // A stalled result holds its value and mark.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // The end of a list always starts a readout, which holds off the input.
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after end of list");

  // A full group starts a readout, so while the input is open at most one value short
  // of a full buffer is gathering, plus the two results the output queue can hold.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> pend_q <= 8'(MAX_GROUP + 1))
    else $error("pending count out of range");

  // No result is delivered without a value behind it.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pend_q != '0)
    else $error("result delivered with nothing pending");

endmodule

bind k_group_stream_reverser_core krev_checker #(
  .MAX_GROUP (MAX_GROUP)
) u_krev_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- dv/k_group_stream_reverser_core_tb.sv -----
`timescale 1ns / 100ps

module k_group_stream_reverser_core_tb;

  localparam int GROUP_DEPTH   = krev_pkg::MAX_GROUP_DEF;
  localparam int DATA_W        = krev_pkg::DATA_W;
  localparam int CFG_W         = krev_pkg::CFG_W;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  // One value of the list together with its end-of-list mark.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } beat_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_W-1:0]         cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic signed [DATA_W-1:0] s_axis_tdata  = '0;
  logic                     s_axis_tlast  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic signed [DATA_W-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  // Stimulus and prediction state.
  beat_t                    beat_queue[$];
  beat_t                    expected_beats[$];
  logic signed [DATA_W-1:0] gather_buf[$];
  logic [CFG_W-1:0]         group_size_q = krev_pkg::GROUP_SIZE_RST;
  int                       sent_count   = 0;
  int                       taken_count  = 0;
  int                       error_count  = 0;
  int                       src_idle_pct = 8;
  int                       dst_idle_pct = 8;
  int                       rx_hold_cnt  = 0;
  logic                     in_taken     = 1'b0;
  beat_t                    drv_beat;
  logic                     drv_valid;
  beat_t                    want_beat;

  k_group_stream_reverser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] value
    .s_axis_tlast  (s_axis_tlast),   // last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] value_res
    .m_axis_tlast  (m_axis_tlast)    // last_res
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Group size as the block applies it: zero acts as one, large sizes saturate.
  function automatic int unsigned applied_group_size(logic [CFG_W-1:0] size);
    if (size == '0) begin
      return 1;
    end
    if (size > GROUP_DEPTH) begin
      return GROUP_DEPTH;
    end
    return size;
  endfunction

  // Gathers one accepted value and queues the reordered values that it releases.
  task automatic predict_reorder(beat_t beat);
    int unsigned k;
    int          n;
    beat_t       res;
    k = applied_group_size(group_size_q);
    if (gather_buf.size() < GROUP_DEPTH) begin
      gather_buf.insert(gather_buf.size(), beat.value);
    end
    n = gather_buf.size();
    if (n >= k) begin
      // A complete group leaves newest first.
      for (int i = n - 1; i >= 0; i--) begin
        res.value = gather_buf[i];
        res.last  = beat.last && (i == 0);
        expected_beats.insert(expected_beats.size(), res);
      end
      gather_buf.delete();
    end else if (beat.last) begin
      // A short tail at the end of the list leaves in arrival order.
      for (int i = 0; i < n; i++) begin
        res.value = gather_buf[i];
        res.last  = (i == n - 1);
        expected_beats.insert(expected_beats.size(), res);
      end
      gather_buf.delete();
    end
  endtask

  task automatic note_error(string what, beat_t want, beat_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected value=%0d last=%0b, got value=%0d last=%0b", $realtime,
               what, want.value, want.last, got.value, got.last);
    end
  endtask

  // Monitor: predicts every input transfer and checks every output transfer.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken_count++;
      predict_reorder('{value: s_axis_tdata, last: s_axis_tlast});
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        note_error("unexpected output", '0, '{value: m_axis_tdata, last: m_axis_tlast});
      end else begin
        want_beat = expected_beats.pop_front();
        if (m_axis_tdata !== want_beat.value) begin
          note_error("value_res mismatch", want_beat,
                     '{value: m_axis_tdata, last: m_axis_tlast});
        end else if (m_axis_tlast !== want_beat.last) begin
          note_error("last_res mismatch", want_beat,
                     '{value: m_axis_tdata, last: m_axis_tlast});
        end
      end
    end
  end

  // Driver: holds an offered value until its transfer, then takes the next one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      drv_valid = s_axis_tvalid;
      drv_beat  = '{value: s_axis_tdata, last: s_axis_tlast};
      if (s_axis_tvalid && in_taken) begin
        drv_valid = 1'b0;
      end
      if (!drv_valid && beat_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_beat  = beat_queue.pop_front();
        drv_valid = 1'b1;
      end
      s_axis_tvalid <= drv_valid;
      s_axis_tdata  <= drv_beat.value;
      s_axis_tlast  <= drv_beat.last;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cnt   <= rx_hold_cnt - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_beat(logic signed [DATA_W-1:0] value, logic last);
    beat_queue.insert(beat_queue.size(), '{value: value, last: last});
    sent_count++;
  endtask

  // Waits until every queued value has been taken and every expected result has come.
  task automatic wait_results_done();
    do begin
      @(negedge clk_i);
    end while (beat_queue.size() != 0 || taken_count != sent_count ||
               expected_beats.size() != 0);
  endtask

  // Writes the group size once every queued value is taken and every expected result has come.
  task automatic set_group_size(logic [CFG_W-1:0] size);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    group_size_q = size;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus: directed lists first, then random lists under several group sizes.
  initial begin
    int unsigned size_pick;
    int          left;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Group size one after reset: values pass straight through.
    push_beat(32'sh7FFF_FFFF, 1'b0);
    push_beat(32'sh8000_0000, 1'b1);

    // A full group on the last value, then a group followed by a short tail.
    set_group_size(CFG_W'(3));
    push_beat(32'sd1, 1'b0);
    push_beat(32'sd2, 1'b0);
    push_beat(32'sd3, 1'b1);
    push_beat(-32'sd1, 1'b0);
    push_beat(32'sd0, 1'b0);
    push_beat(32'sh5555_5555, 1'b0);
    push_beat(32'shAAAA_AAAA, 1'b1);

    // The largest register value saturates to the buffer depth.
    set_group_size('1);
    for (int i = 0; i < GROUP_DEPTH; i++) begin
      push_beat(pick_value(), i == GROUP_DEPTH - 1);
    end

    // Size zero behaves as size one.
    set_group_size('0);
    push_beat(32'sh1234_5678, 1'b0);
    push_beat(-32'sh1234_5678, 1'b1);

    // Lowering the size while values are pending releases them all as one group.
    set_group_size(CFG_W'(8));
    push_beat(32'sd10, 1'b0);
    push_beat(32'sd11, 1'b0);
    push_beat(32'sd12, 1'b0);
    set_group_size(CFG_W'(2));
    push_beat(32'sd13, 1'b0);
    push_beat(32'sd14, 1'b1);

    // Random lists; a phase may end in the middle of a list.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       size_pick = GROUP_DEPTH;
        1:       size_pick = 1;
        2:       size_pick = $urandom_range(2, 8);
        default: size_pick = $urandom_range(2 ** CFG_W - 1);
      endcase
      set_group_size(CFG_W'(size_pick));
      @(posedge clk_i);
      if (phase == 2) begin
        rx_hold_cnt = HOLD_CYCLES;
      end
      src_idle_pct = (phase == 3) ? 0 : 8;
      dst_idle_pct = (phase == 3) ? 0 : 8;
      left = 0;
      for (int j = 0; j < 19; j++) begin
        if (left == 0) begin
          left = $urandom_range(1, 2 * applied_group_size(CFG_W'(size_pick)) + 2);
        end
        left--;
        push_beat(pick_value(), left == 0);
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
